// File: rtl/core/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
// Used by mm_ctrl, mm_datapath and matrix_multiply_top; depends on nothing.
`default_nettype none
package mm_pkg;

  localparam int IDX_W  = 3;
  localparam int SIZE_W = 4;
  localparam int ACT_W  = 2;
  localparam int REG_W  = 2;

  localparam logic [ACT_W-1:0] ACT_WR_A    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_B    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  localparam logic [REG_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [REG_W-1:0] REG_B_COLS    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic             rd;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] k;
    logic             first;
    logic             last_k;
    logic             last_elem;
  } cmd_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic             first;
    logic             last_k;
    logic             last_elem;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/core/mm_ctrl.sv
// Controller: size registers, item decode and the row/column/inner-index sequencer.
// Depends on mm_pkg; drives mm_datapath through an mm_pkg::cmd_t command.
`default_nettype none
module mm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire [mm_pkg::ACT_W-1:0]    action,
  input  wire [mm_pkg::IDX_W-1:0]    row,
  input  wire [mm_pkg::IDX_W-1:0]    col,
  input  wire                        wr_en,
  input  wire [mm_pkg::REG_W-1:0]    wr_index,
  input  wire [mm_pkg::SIZE_W-1:0]   wr_data,
  output logic                       busy,
  output mm_pkg::cmd_t               cmd
);

  localparam logic [mm_pkg::SIZE_W-1:0] MAX_SIZE = mm_pkg::SIZE_W'(MAX_DIM);

  logic [mm_pkg::SIZE_W-1:0] a_rows;
  logic [mm_pkg::SIZE_W-1:0] inner_len;
  logic [mm_pkg::SIZE_W-1:0] b_cols;
  logic [mm_pkg::SIZE_W-1:0] nr;
  logic [mm_pkg::SIZE_W-1:0] nk;
  logic [mm_pkg::SIZE_W-1:0] nc;

  mm_pkg::state_t           state, state_next;
  logic [mm_pkg::IDX_W-1:0] r, r_next;
  logic [mm_pkg::IDX_W-1:0] c, c_next;
  logic [mm_pkg::IDX_W-1:0] k, k_next;
  logic [mm_pkg::IDX_W-1:0] nr_m1, nr_m1_next;
  logic [mm_pkg::IDX_W-1:0] nk_m1, nk_m1_next;
  logic [mm_pkg::IDX_W-1:0] nc_m1, nc_m1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= MAX_SIZE;
      inner_len <= MAX_SIZE;
      b_cols    <= MAX_SIZE;
    end else if (wr_en) begin
      unique case (wr_index)
        mm_pkg::REG_A_ROWS:    a_rows    <= wr_data;
        mm_pkg::REG_INNER_LEN: inner_len <= wr_data;
        mm_pkg::REG_B_COLS:    b_cols    <= wr_data;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one, and a size above MAX_DIM acts as MAX_DIM.
  always_comb begin
    nr = (a_rows == '0) ? mm_pkg::SIZE_W'(1) : ((a_rows > MAX_SIZE) ? MAX_SIZE : a_rows);
    nk = (inner_len == '0) ? mm_pkg::SIZE_W'(1)
                           : ((inner_len > MAX_SIZE) ? MAX_SIZE : inner_len);
    nc = (b_cols == '0) ? mm_pkg::SIZE_W'(1) : ((b_cols > MAX_SIZE) ? MAX_SIZE : b_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm_pkg::ST_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
      nr_m1 <= '0;
      nk_m1 <= '0;
      nc_m1 <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
      nr_m1 <= nr_m1_next;
      nk_m1 <= nk_m1_next;
      nc_m1 <= nc_m1_next;
    end
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    nr_m1_next = nr_m1;
    nk_m1_next = nk_m1;
    nc_m1_next = nc_m1;
    cmd        = '0;
    cmd.r      = r;
    cmd.c      = c;
    cmd.k      = k;
    busy       = (state == mm_pkg::ST_RUN);
    unique case (state)
      mm_pkg::ST_IDLE: begin
        if (start) begin
          unique case (action)
            mm_pkg::ACT_WR_A: begin
              cmd.we_a = ({1'b0, row} < nr) && ({1'b0, col} < nk);
            end
            mm_pkg::ACT_WR_B: begin
              cmd.we_b = ({1'b0, row} < nk) && ({1'b0, col} < nc);
            end
            mm_pkg::ACT_COMPUTE: begin
              state_next = mm_pkg::ST_RUN;
              r_next     = '0;
              c_next     = '0;
              k_next     = '0;
              nr_m1_next = mm_pkg::IDX_W'(nr - mm_pkg::SIZE_W'(1));
              nk_m1_next = mm_pkg::IDX_W'(nk - mm_pkg::SIZE_W'(1));
              nc_m1_next = mm_pkg::IDX_W'(nc - mm_pkg::SIZE_W'(1));
            end
            default: ;
          endcase
        end
      end
      mm_pkg::ST_RUN: begin
        cmd.rd        = 1'b1;
        cmd.first     = (k == '0);
        cmd.last_k    = (k == nk_m1);
        cmd.last_elem = (k == nk_m1) && (c == nc_m1) && (r == nr_m1);
        if (k != nk_m1) begin
          k_next = k + mm_pkg::IDX_W'(1);
        end else begin
          k_next = '0;
          if (c != nc_m1) begin
            c_next = c + mm_pkg::IDX_W'(1);
          end else begin
            c_next = '0;
            if (r != nr_m1) begin
              r_next = r + mm_pkg::IDX_W'(1);
            end else begin
              r_next     = '0;
              state_next = mm_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_next = mm_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/mm_datapath.sv
// Datapath: the A and B element memories, a registered multiplier and the accumulator.
// Depends on mm_pkg; takes its commands from mm_ctrl.
`default_nettype none
module mm_datapath #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int SUM_W      = 2 * ELEM_WIDTH + 3
) (
  input  wire                            clk,
  input  wire                            rst,
  input  mm_pkg::cmd_t                   cmd,
  input  wire [mm_pkg::IDX_W-1:0]        row,
  input  wire [mm_pkg::IDX_W-1:0]        col,
  input  wire signed [ELEM_WIDTH-1:0]    value,
  output logic                           out_valid,
  output logic [mm_pkg::IDX_W-1:0]       out_row,
  output logic [mm_pkg::IDX_W-1:0]       out_col,
  output logic signed [SUM_W-1:0]        sum,
  output logic                           last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [ELEM_WIDTH-1:0]   a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0]   b_mem [DEPTH];
  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  a_addr;
  logic [AW-1:0]                  b_addr;
  logic signed [ELEM_WIDTH-1:0]   a_q;
  logic signed [ELEM_WIDTH-1:0]   b_q;
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [SUM_W-1:0]        acc;
  logic signed [SUM_W-1:0]        acc_next;
  mm_pkg::stage_t                 st1;
  mm_pkg::stage_t                 st2;

  assign wr_addr = AW'(row * MAX_DIM + col);
  assign a_addr  = AW'(cmd.r * MAX_DIM + cmd.k);
  assign b_addr  = AW'(cmd.k * MAX_DIM + cmd.c);

  always_ff @(posedge clk) begin
    if (cmd.we_a) begin
      a_mem[wr_addr] <= value;
    end
    if (cmd.we_b) begin
      b_mem[wr_addr] <= value;
    end
    a_q <= a_mem[a_addr];
    b_q <= b_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.vld <= 1'b0;
      st2.vld <= 1'b0;
    end else begin
      st1.vld <= cmd.rd;
      st2.vld <= st1.vld;
    end
    st1.r         <= cmd.r;
    st1.c         <= cmd.c;
    st1.first     <= cmd.first;
    st1.last_k    <= cmd.last_k;
    st1.last_elem <= cmd.last_elem;
    st2.r         <= st1.r;
    st2.c         <= st1.c;
    st2.first     <= st1.first;
    st2.last_k    <= st1.last_k;
    st2.last_elem <= st1.last_elem;
    prod          <= a_q * b_q;
  end

  assign acc_next = st2.first ? SUM_W'(prod) : (acc + SUM_W'(prod));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= st2.vld && st2.last_k;
    end
    if (st2.vld) begin
      acc <= acc_next;
    end
    if (st2.vld && st2.last_k) begin
      sum     <= acc_next;
      out_row <= st2.r;
      out_col <= st2.c;
      last    <= st2.last_elem;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/matrix_multiply_top.sv
// Top level of the matrix multiply block: joins mm_ctrl and mm_datapath.
// Depends on mm_pkg, mm_ctrl and mm_datapath.
`default_nettype none
// Element writes (action 0 for A, 1 for B) are accepted back to back. A compute item
// holds busy while it reads a_rows * b_cols * inner_len term pairs, each size taken as
// its register clamped to 1..MAX_DIM, one multiply and accumulate per cycle through a
// single shared multiplier fed by one read port of each element memory. Each product
// element appears on out_valid for one cycle, in row-major order, after its last term
// passes the memory read, product and output registers; results must be taken as they
// come. The final element carries last. Sizes take effect at the next compute.
module matrix_multiply_top #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire [mm_pkg::ACT_W-1:0]            action,
  input  wire [mm_pkg::IDX_W-1:0]            row,
  input  wire [mm_pkg::IDX_W-1:0]            col,
  input  wire signed [ELEM_WIDTH-1:0]        value,
  input  wire                                wr_en,
  input  wire [mm_pkg::REG_W-1:0]            wr_index,
  input  wire [mm_pkg::SIZE_W-1:0]           wr_data,
  output logic                               out_valid,
  output logic [mm_pkg::IDX_W-1:0]           out_row,
  output logic [mm_pkg::IDX_W-1:0]           out_col,
  output logic signed [2*ELEM_WIDTH+2:0]     sum,
  output logic                               last
);

  mm_pkg::cmd_t cmd;

  mm_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .action   (action),
    .row      (row),
    .col      (col),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .busy     (busy),
    .cmd      (cmd)
  );

  mm_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .SUM_W      (2 * ELEM_WIDTH + 3)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .sum       (sum),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action == mm_pkg::ACT_COMPUTE) |=> busy)
    else $error("compute item did not raise busy");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action != mm_pkg::ACT_COMPUTE) |=> !busy)
    else $error("element write raised busy");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |=> !$past(cmd.rd))
    else $error("memory read issued while idle");

  a_last_marks_result: assert property (@(posedge clk) disable iff (rst)
    last && out_valid |=> !out_valid || !$stable(out_row) || !$stable(out_col) || !last)
    else $error("final element repeated");
`endif

endmodule
`default_nettype wire

// File: bench/mm_product_checker.sv
// Checker for the matrix multiply block: follows element loads, size register writes and
// compute items, predicts each product element and compares it with what the block emits.
// Depends on mm_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps
module mm_product_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire               busy,
  input  wire [1:0]         action,
  input  wire [2:0]         row,
  input  wire [2:0]         col,
  input  wire signed [15:0] value,
  input  wire               wr_en,
  input  wire [1:0]         wr_index,
  input  wire [3:0]         wr_data,
  input  wire               out_valid,
  input  wire [2:0]         out_row,
  input  wire [2:0]         out_col,
  input  wire signed [34:0] sum,
  input  wire               last,
  output int                fail_count,
  output int                pending,
  output int                checked
);

  typedef struct packed {
    logic [2:0]         r;
    logic [2:0]         c;
    logic signed [34:0] s;
    logic               l;
  } elem_t;

  elem_t              product_q[$];
  logic [3:0]         rows_reg;
  logic [3:0]         inner_reg;
  logic [3:0]         cols_reg;
  logic signed [15:0] a_mem [0:63];
  logic signed [15:0] b_mem [0:63];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    rows_reg   = 4'd8;
    inner_reg  = 4'd8;
    cols_reg   = 4'd8;
  end

  function automatic int clamp_size(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  function automatic void predict_product();
    int    nr;
    int    nk;
    int    nc;
    longint acc;
    elem_t e;
    nr = clamp_size(rows_reg);
    nk = clamp_size(inner_reg);
    nc = clamp_size(cols_reg);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_mem[r * 8 + k]) * longint'(b_mem[k * 8 + c]);
        end
        e.r = r[2:0];
        e.c = c[2:0];
        e.s = acc[34:0];
        e.l = (r == nr - 1) && (c == nc - 1);
        product_q.push_back(e);
      end
    end
  endfunction

  function automatic void store_element(logic [1:0] act, logic [2:0] r, logic [2:0] c,
                                        logic signed [15:0] v);
    int nr;
    int nk;
    int nc;
    nr = clamp_size(rows_reg);
    nk = clamp_size(inner_reg);
    nc = clamp_size(cols_reg);
    if (act == mm_pkg::ACT_WR_A && r < nr && c < nk) a_mem[{r, c}] = v;
    if (act == mm_pkg::ACT_WR_B && r < nk && c < nc) b_mem[{r, c}] = v;
  endfunction

  // Results are compared before a new compute is queued, so a result and an accepted
  // item on the same edge never pair up wrongly.
  always @(posedge clk) begin
    elem_t exp_elem;
    if (rst) begin
      rows_reg  = 4'd8;
      inner_reg = 4'd8;
      cols_reg  = 4'd8;
      product_q.delete();
    end else begin
      if (out_valid) begin
        checked++;
        if (product_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mm_checker: unexpected product element row %0d col %0d sum %0d",
                     out_row, out_col, sum);
        end else begin
          exp_elem = product_q.pop_front();
          if (out_row !== exp_elem.r || out_col !== exp_elem.c || sum !== exp_elem.s ||
              last !== exp_elem.l) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mm_checker: mismatch, expected row %0d col %0d sum %0d last %0b",
                       exp_elem.r, exp_elem.c, $signed(exp_elem.s), exp_elem.l);
              $display("mm_checker:                got row %0d col %0d sum %0d last %0b",
                       out_row, out_col, sum, last);
            end
          end
        end
      end
      if (start && !busy) begin
        if (action == mm_pkg::ACT_COMPUTE) predict_product();
        else store_element(action, row, col, value);
      end
      if (wr_en) begin
        case (wr_index)
          mm_pkg::REG_A_ROWS:    rows_reg = wr_data;
          mm_pkg::REG_INNER_LEN: inner_reg = wr_data;
          mm_pkg::REG_B_COLS:    cols_reg = wr_data;
          default: ;
        endcase
      end
    end
    pending = product_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Top of the matrix multiply testbench: clock, reset, element and size stimulus, verdict.
// Depends on mm_pkg, matrix_multiply_top and mm_product_checker.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [mm_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE = 8;

  logic               clk;
  logic               rst;
  logic               start;
  logic [1:0]         action;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [15:0] value;
  logic               wr_en;
  logic [1:0]         wr_index;
  logic [3:0]         wr_data;
  wire                busy;
  wire                out_valid;
  wire [2:0]          out_row;
  wire [2:0]          out_col;
  wire signed [34:0]  sum;
  wire                last;
  int                 fail_count;
  int                 pending;
  int                 checked;

  bit a_loaded [0:63];
  bit b_loaded [0:63];
  int nr;
  int nk;
  int nc;
  int counted;
  int sent;
  int computes;
  int settings;
  bit idle_en;

  matrix_multiply_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .row(row), .col(col), .value(value),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .out_valid(out_valid), .out_row(out_row), .out_col(out_col), .sum(sum), .last(last)
  );

  mm_product_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .row(row), .col(col), .value(value),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .out_valid(out_valid), .out_row(out_row), .out_col(out_col), .sum(sum), .last(last),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int clamp_size(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  function automatic logic [3:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 4'($urandom_range(3, 1));
    if (p < 75) return 4'($urandom_range(8, 4));
    if (p < 83) return 4'd0;
    if (p < 92) return 4'd8;
    return 4'($urandom_range(15, 9));
  endfunction

  task automatic set_sizes(logic [3:0] ar, logic [3:0] il, logic [3:0] bc);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= mm_pkg::REG_A_ROWS;
    wr_data <= ar;
    @(negedge clk);
    wr_index <= mm_pkg::REG_INNER_LEN;
    wr_data <= il;
    @(negedge clk);
    wr_index <= mm_pkg::REG_B_COLS;
    wr_data <= bc;
    @(negedge clk);
    wr_en <= 1'b0;
    nr = clamp_size(ar);
    nk = clamp_size(il);
    nc = clamp_size(bc);
    settings++;
  endtask

  task automatic send_item(logic [1:0] act, logic [2:0] r, logic [2:0] c,
                           logic signed [15:0] v);
    if (idle_en && $urandom_range(99) < 22) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    row <= r;
    col <= c;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    if (act == mm_pkg::ACT_WR_A && r < nr && c < nk) begin
      a_loaded[{r, c}] = 1'b1;
      counted++;
    end else if (act == mm_pkg::ACT_WR_B && r < nk && c < nc) begin
      b_loaded[{r, c}] = 1'b1;
      counted++;
    end else if (act == mm_pkg::ACT_COMPUTE) begin
      computes++;
      counted++;
    end
  endtask

  // Waits until every expected element has come back, then gives the pipeline time to empty.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy !== 1'b0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // A compute may only read entries that were loaded, so any gaps are filled first.
  task automatic compute_product();
    for (int r = 0; r < nr; r++)
      for (int k = 0; k < nk; k++)
        if (!a_loaded[r * 8 + k])
          send_item(mm_pkg::ACT_WR_A, r[2:0], k[2:0], 16'($urandom));
    for (int k = 0; k < nk; k++)
      for (int c = 0; c < nc; c++)
        if (!b_loaded[k * 8 + c])
          send_item(mm_pkg::ACT_WR_B, k[2:0], c[2:0], 16'($urandom));
    send_item(mm_pkg::ACT_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  task automatic random_item();
    int p;
    p = $urandom_range(99);
    if (p < 44)
      send_item(mm_pkg::ACT_WR_A, 3'($urandom_range(nr - 1)), 3'($urandom_range(nk - 1)),
                16'($urandom));
    else if (p < 88)
      send_item(mm_pkg::ACT_WR_B, 3'($urandom_range(nk - 1)), 3'($urandom_range(nc - 1)),
                16'($urandom));
    else if (p < 95)
      send_item($urandom_range(1) ? mm_pkg::ACT_WR_A : mm_pkg::ACT_WR_B,
                3'($urandom), 3'($urandom), 16'($urandom));
    else
      send_item(ACT_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  initial begin
    int phase;
    rst = 1'b1;
    start = 1'b0;
    action = mm_pkg::ACT_WR_A;
    row = 3'd0;
    col = 3'd0;
    value = 16'sd0;
    wr_en = 1'b0;
    wr_index = mm_pkg::REG_A_ROWS;
    wr_data = 4'd0;
    idle_en = 1'b1;
    nr = 8;
    nk = 8;
    nc = 8;
    counted = 0;
    sent = 0;
    computes = 0;
    settings = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // A single row times a single column of full length, all at the most negative element,
    // gives the largest sum; then in- and out-of-size writes, the unused action and a compute.
    set_sizes(4'd0, 4'd12, 4'd0);
    for (int k = 0; k < 8; k++) begin
      send_item(mm_pkg::ACT_WR_A, 3'd0, k[2:0], -16'sd32768);
      send_item(mm_pkg::ACT_WR_B, k[2:0], 3'd0, -16'sd32768);
    end
    send_item(mm_pkg::ACT_COMPUTE, 3'd0, 3'd0, 16'sd0);
    send_item(mm_pkg::ACT_WR_A, 3'd1, 3'd0, 16'sh1234);
    send_item(mm_pkg::ACT_WR_B, 3'd0, 3'd1, 16'sh7fff);
    send_item(ACT_UNUSED, 3'd7, 3'd7, 16'sh7fff);
    send_item(mm_pkg::ACT_WR_B, 3'd3, 3'd0, 16'sh7fff);
    send_item(mm_pkg::ACT_WR_B, 3'd5, 3'd0, 16'sd0);
    send_item(mm_pkg::ACT_COMPUTE, 3'd7, 3'd7, -16'sd1);
    drain();

    counted = 0;
    phase = 0;
    while (counted < 100) begin
      idle_en = (phase != 2);
      if (phase == 0) set_sizes(4'd8, 4'd2, 4'd15);
      else if (phase == 1) set_sizes(4'd1, 4'd1, 4'd1);
      else set_sizes(pick_size(), pick_size(), pick_size());
      repeat ($urandom_range(2, 1)) begin
        repeat ($urandom_range(16, 3)) random_item();
        compute_product();
      end
      drain();
      phase++;
    end

    $display("Run covered %0d items, %0d of them computes, under %0d size settings.",
             sent, computes, settings);
    $display("%0d product elements compared, %0d failures.", checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
